// ===== src/partial_fraction_rational_eval_top_macros.svh =====
// Assertion macros for the partial-fraction evaluator RTL.
`ifndef PARTIAL_FRACTION_RATIONAL_EVAL_TOP_MACROS_SVH
`define PARTIAL_FRACTION_RATIONAL_EVAL_TOP_MACROS_SVH
`ifndef SYNTH
`define PFRE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfre assertion failed");
`define PFRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfre assertion failed");
`else
`define PFRE_ASSERT(lbl, prop)
`define PFRE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/pfre_pkg.sv =====
// Types and constants shared by the partial-fraction evaluator modules.
package pfre_pkg;

    localparam int MAX_POLES = 16;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int PCNT_W    = 5;
    localparam int TBL_AW    = $clog2(MAX_POLES);
    localparam int LIM_W     = $clog2(MAX_POLES + 1);
    localparam int NUM_W     = Q_W + FRAC_BITS;
    localparam int DEN_W     = Q_W + 1;
    localparam int BIT_W     = $clog2(NUM_W);
    localparam int ACC_W     = Q_W + LIM_W + 1;
    localparam int IDX_W     = 4;
    localparam int IN_W      = ((IDX_W + 3 * Q_W + 7) / 8) * 8;
    localparam int CFG_AW    = 1;

    localparam logic [CFG_AW-1:0] CFG_POLE_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_NORM       = 1'b1;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FETCH,
        ST_SETUP,
        ST_DIV,
        ST_ACCUM,
        ST_FINISH
    } state_t;

    typedef struct packed
    {
        logic              load_we;
        logic              eval_start;
        logic              fetch;
        logic              setup;
        logic              div_step;
        logic              accum;
        logic              finish;
        logic [TBL_AW-1:0] rd_addr;
    } cmd_t;

    typedef struct packed
    {
        logic             out_busy;
        logic [LIM_W-1:0] pole_lim;
    } stat_t;

endpackage

// ===== src/pfre_ctrl.sv =====
// Sequencer for the partial-fraction evaluator: walks poles and divider steps.
`include "partial_fraction_rational_eval_top_macros.svh"
module pfre_ctrl
    import pfre_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  op_t   in_op,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [LIM_W-1:0] k_reg, k_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [LIM_W-1:0] k_inc;

    assign k_inc = k_reg + LIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        bit_next    = bit_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.rd_addr = k_reg[TBL_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.eval_start = 1'b1;
                        k_next         = '0;
                        if (stat.pole_lim == '0)
                            state_next = ST_FINISH;
                        else
                            state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(NUM_W - 1))
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                k_next    = k_inc;
                if (k_inc == stat.pole_lim)
                    state_next = ST_FINISH;
                else
                    state_next = ST_FETCH;
            end
            ST_FINISH:
            begin
                // The result register must be free before the sum is written out.
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PFRE_ASSERT_IMP(a_finish_free, cmd.finish, !stat.out_busy)
    `PFRE_ASSERT(a_start_leaves_idle, cmd.eval_start |=> (state_reg != ST_IDLE))
    `PFRE_ASSERT_IMP(a_accum_after_div, state_reg == ST_ACCUM, $past(state_reg) == ST_DIV)

endmodule

// ===== src/pfre_dp.sv =====
// Datapath: coefficient tables, config registers, serial divider and accumulator.
module pfre_dp
    import pfre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              cfg_valid,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [Q_W-1:0]    cfg_data,
    input  logic [IDX_W-1:0]  in_index,
    input  logic [Q_W-1:0]    in_residue,
    input  logic [Q_W-1:0]    in_pole_shift,
    input  logic [Q_W-1:0]    in_x,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_y,
    output logic              out_saturated,
    output logic              out_div_zero
);

    localparam logic [NUM_W-1:0] TERM_POS_MAX = NUM_W'({1'b0, {(Q_W-1){1'b1}}});
    localparam logic [NUM_W-1:0] TERM_NEG_MAX = NUM_W'({1'b1, {(Q_W-1){1'b0}}});
    localparam logic [Q_W-1:0]   Q_MAX_V      = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]   Q_MIN_V      = {1'b1, {(Q_W-1){1'b0}}};

    logic [Q_W-1:0] res_mem  [MAX_POLES];
    logic [Q_W-1:0] pole_mem [MAX_POLES];

    logic [PCNT_W-1:0] pole_count_reg;
    logic [Q_W-1:0]    norm_reg;
    logic [Q_W-1:0]    x_reg;
    logic [Q_W-1:0]    res_rd_reg;
    logic [Q_W-1:0]    pole_rd_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  dmag_reg;
    logic              neg_reg;
    logic              dz_term_reg;
    logic              r_zero_reg;
    logic              r_neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic              sat_reg;
    logic              dz_reg;
    logic              out_valid_reg;
    logic [Q_W-1:0]    y_reg;
    logic              out_sat_reg;
    logic              out_dz_reg;

    logic signed [DEN_W-1:0] den;
    logic [DEN_W-1:0]        den_mag;
    logic [Q_W-1:0]          r_mag;
    logic [DEN_W:0]          rem_sh;
    logic [DEN_W+1:0]        diff;
    logic [Q_W-1:0]          term;
    logic                    term_sat;
    logic                    acc_hi;
    logic                    acc_lo;
    logic [LIM_W-1:0]        pole_lim;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg <= PCNT_W'(1);
            norm_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLE_COUNT: pole_count_reg <= cfg_data[PCNT_W-1:0];
                CFG_NORM:       norm_reg       <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(pole_count_reg) > MAX_POLES)
            pole_lim = LIM_W'(MAX_POLES);
        else
            pole_lim = LIM_W'(pole_count_reg);
    end

    assign stat.pole_lim = pole_lim;
    assign stat.out_busy = out_valid_reg && !out_ready;

    // Coefficient tables, one write and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            res_mem[in_index[TBL_AW-1:0]]  <= in_residue;
            pole_mem[in_index[TBL_AW-1:0]] <= in_pole_shift;
        end
        if (cmd.fetch)
        begin
            res_rd_reg  <= res_mem[cmd.rd_addr];
            pole_rd_reg <= pole_mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        den     = $signed({x_reg[Q_W-1], x_reg}) + $signed({pole_rd_reg[Q_W-1], pole_rd_reg});
        den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        r_mag   = res_rd_reg[Q_W-1] ? (~res_rd_reg + Q_W'(1)) : res_rd_reg;
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        diff    = {1'b0, rem_sh} - {2'b00, dmag_reg};
    end

    // Term selection: sign and clip the quotient; a zero divisor gives 0 or a bound.
    always_comb
    begin
        term_sat = 1'b0;
        if (dz_term_reg)
        begin
            term_sat = !r_zero_reg;
            if (r_zero_reg)
                term = '0;
            else if (r_neg_reg)
                term = Q_MIN_V;
            else
                term = Q_MAX_V;
        end
        else if (!neg_reg)
        begin
            if (quo_reg > TERM_POS_MAX)
            begin
                term     = Q_MAX_V;
                term_sat = 1'b1;
            end
            else
            begin
                term = quo_reg[Q_W-1:0];
            end
        end
        else
        begin
            if (quo_reg > TERM_NEG_MAX)
            begin
                term     = Q_MIN_V;
                term_sat = 1'b1;
            end
            else
            begin
                term = ~quo_reg[Q_W-1:0] + Q_W'(1);
            end
        end
    end

    assign acc_hi = acc_reg > $signed(ACC_W'($signed(Q_MAX_V)));
    assign acc_lo = acc_reg < $signed(ACC_W'($signed(Q_MIN_V)));

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            x_reg   <= in_x;
            acc_reg <= ACC_W'($signed(norm_reg));
            sat_reg <= 1'b0;
            dz_reg  <= 1'b0;
        end
        if (cmd.setup)
        begin
            quo_reg     <= {r_mag, {FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
            dmag_reg    <= den_mag;
            neg_reg     <= res_rd_reg[Q_W-1] ^ den[DEN_W-1];
            dz_term_reg <= (den == '0);
            r_zero_reg  <= (res_rd_reg == '0);
            r_neg_reg   <= res_rd_reg[Q_W-1];
        end
        if (cmd.div_step)
        begin
            // One restoring step: a borrow means the divisor did not fit.
            if (!diff[DEN_W+1])
            begin
                rem_reg <= diff[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.accum)
        begin
            acc_reg <= acc_reg + ACC_W'($signed(term));
            sat_reg <= sat_reg | term_sat;
            dz_reg  <= dz_reg | dz_term_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (acc_hi)
                y_reg <= Q_MAX_V;
            else if (acc_lo)
                y_reg <= Q_MIN_V;
            else
                y_reg <= acc_reg[Q_W-1:0];
            out_sat_reg <= sat_reg | acc_hi | acc_lo;
            out_dz_reg  <= dz_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_y         = y_reg;
    assign out_saturated = out_sat_reg;
    assign out_div_zero  = out_dz_reg;

endmodule

// ===== src/partial_fraction_rational_eval_top.sv =====
// Top level of the partial-fraction rational evaluator.
// Computes y = norm + sum of residue[k] / (x + pole[k]) for k below n in
// signed Q16.16. A load word (tuser 0) writes one residue/pole pair and gives no
// result. An evaluate word (tuser 1) walks n poles, n being pole_count limited to
// 16: per pole one table read, one setup step, a one-bit-per-cycle restoring
// divider over the 48-bit quotient and one accumulate step. The divider sets
// the rate. One word is worked on at a time; a finished result waits in the output
// register while the next word is accepted. Configuration writes are always taken.
module partial_fraction_rational_eval_top
    import pfre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // index [3:0], residue [35:4], pole_shift [67:36], x [99:68], zero pad above
    input  logic [IN_W-1:0]   s_axis_tdata,
    // operation [0]
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // y [31:0]
    output logic [Q_W-1:0]    m_axis_tdata,
    // saturated [0], div_zero [1]
    output logic [1:0]        m_axis_tuser,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [Q_W-1:0]    cfg_data
);

    localparam int RES_LO  = IDX_W;
    localparam int POLE_LO = IDX_W + Q_W;
    localparam int X_LO    = IDX_W + 2 * Q_W;

    cmd_t  cmd;
    stat_t stat;
    op_t   in_op;

    assign in_op     = op_t'(s_axis_tuser);
    assign cfg_ready = 1'b1;

    pfre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (in_op),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfre_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_index      (s_axis_tdata[IDX_W-1:0]),
        .in_residue    (s_axis_tdata[RES_LO +: Q_W]),
        .in_pole_shift (s_axis_tdata[POLE_LO +: Q_W]),
        .in_x          (s_axis_tdata[X_LO +: Q_W]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_y         (m_axis_tdata),
        .out_saturated (m_axis_tuser[0]),
        .out_div_zero  (m_axis_tuser[1])
    );

endmodule
